>>> rtl/mfw_pkg.sv
// ----------------------------------------------------------------------------
// mfw_pkg
// shared sizes, codes, types and expansion tables of the mono frame writer
// ----------------------------------------------------------------------------
package mfw_pkg;

  localparam int PANEL_WIDTH  = 240;
  localparam int PANEL_HEIGHT = 320;

  localparam int LINE_STRIDE = (PANEL_WIDTH + 7) / 8;
  localparam int STORE_BYTES = LINE_STRIDE * PANEL_HEIGHT;

  localparam int ADDR_W = $clog2(STORE_BYTES);
  localparam int COL_W  = $clog2(PANEL_WIDTH);
  localparam int ROW_W  = $clog2(PANEL_HEIGHT + 1);
  localparam int CUR_W  = 17;
  localparam int REG_W  = 16;
  localparam int IDX_W  = 4;
  localparam int BADDR_W = 14;

  // register indexes
  localparam logic [IDX_W-1:0] REG_AREA_LEFT   = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_AREA_TOP    = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_AREA_RIGHT  = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_AREA_BOTTOM = IDX_W'(3);

  // operation codes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // status codes
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_INVERTED = 1'b1;

  localparam logic [7:0] BYTE_FILL = 8'hFF;
  localparam logic [7:0] MSB_MASK  = 8'h80;

  // luma of 128 or more after the /1000 means weighted sum of 128000 or more
  localparam int LUMA_W = 18;
  localparam logic [LUMA_W-1:0] LUMA_LIMIT = LUMA_W'(128 * 1000);
  localparam logic [9:0] WEIGHT_R = 10'd299;
  localparam logic [9:0] WEIGHT_G = 10'd587;
  localparam logic [9:0] WEIGHT_B = 10'd114;

  localparam logic signed [CUR_W-1:0] PANEL_W_S = CUR_W'(PANEL_WIDTH);
  localparam logic signed [CUR_W-1:0] PANEL_H_S = CUR_W'(PANEL_HEIGHT);

  // 5 bit channel to 8 bits, v * 255 / 31 truncated, as a constant lookup
  function automatic logic [7:0] exp5(logic [4:0] v);
    logic [7:0] t;
    t = '0;
    for (int i = 0; i < 32; i++) begin
      if (v == 5'(i)) t = 8'((i * 255) / 31);
    end
    return t;
  endfunction

  // 6 bit channel to 8 bits, v * 255 / 63 truncated, as a constant lookup
  function automatic logic [7:0] exp6(logic [5:0] v);
    logic [7:0] t;
    t = '0;
    for (int i = 0; i < 64; i++) begin
      if (v == 6'(i)) t = 8'((i * 255) / 63);
    end
    return t;
  endfunction

  // raster position of the current pixel as seen by the datapath
  typedef struct packed {
    logic              reject;
    logic              on_panel;
    logic              last;
    logic [ADDR_W-1:0] addr;
    logic [2:0]        bit_sel;
  } pix_pos_t;

endpackage

>>> rtl/mfw_ram.sv
// ----------------------------------------------------------------------------
// mfw_ram
// single write port, single read port frame byte memory, registered read
// ----------------------------------------------------------------------------
module mfw_ram
  import mfw_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [7:0]        wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [7:0]        rdata
);

  logic [7:0] mem [STORE_BYTES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/mfw_luma.sv
// ----------------------------------------------------------------------------
// mfw_luma
// rgb565 to 8-bit channels, weighted luma sum and threshold
// ----------------------------------------------------------------------------
module mfw_luma
  import mfw_pkg::*;
(
  input  logic [15:0] pixel,
  output logic        bright
);

  logic [7:0]        r8, g8, b8;
  logic [LUMA_W-1:0] sum;

  always_comb begin
    r8 = exp5(pixel[15:11]);
    g8 = exp6(pixel[10:5]);
    b8 = exp5(pixel[4:0]);
    sum = LUMA_W'(r8) * LUMA_W'(WEIGHT_R) + LUMA_W'(g8) * LUMA_W'(WEIGHT_G) +
          LUMA_W'(b8) * LUMA_W'(WEIGHT_B);
    bright = (sum >= LUMA_LIMIT);
  end

endmodule

>>> rtl/mfw_cursor.sv
// ----------------------------------------------------------------------------
// mfw_cursor
// area registers and raster cursor, yields byte address and bit of a pixel
// ----------------------------------------------------------------------------
module mfw_cursor
  import mfw_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_idx,
  input  logic [REG_W-1:0] cfg_wdata,
  input  logic             step,
  output pix_pos_t         pos
);

  logic signed [CUR_W-1:0] area_left, area_top, area_right, area_bottom;
  logic signed [CUR_W-1:0] cursor_col, cursor_row;
  logic signed [CUR_W-1:0] cfg_sext;
  logic                    col_wrap, row_wrap;

  assign cfg_sext = CUR_W'(signed'(cfg_wdata));
  assign col_wrap = (cursor_col >= area_right);
  assign row_wrap = (cursor_row >= area_bottom);

  always_comb begin
    pos.reject   = (area_left > area_right) || (area_top > area_bottom);
    pos.on_panel = (cursor_col >= 0) && (cursor_col < PANEL_W_S) &&
                   (cursor_row >= 0) && (cursor_row < PANEL_H_S);
    pos.last     = col_wrap && row_wrap;
    pos.addr     = ADDR_W'(ADDR_W'(cursor_row[ROW_W-1:0]) * ADDR_W'(LINE_STRIDE)) +
                   ADDR_W'(cursor_col[COL_W-1:3]);
    pos.bit_sel  = cursor_col[2:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      area_left   <= '0;
      area_top    <= '0;
      area_right  <= CUR_W'(239);
      area_bottom <= CUR_W'(319);
      cursor_col  <= '0;
      cursor_row  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_AREA_LEFT: begin
          area_left  <= cfg_sext;
          cursor_col <= cfg_sext;
          cursor_row <= area_top;
        end
        REG_AREA_TOP: begin
          area_top   <= cfg_sext;
          cursor_col <= area_left;
          cursor_row <= cfg_sext;
        end
        REG_AREA_RIGHT: begin
          area_right <= cfg_sext;
          cursor_col <= area_left;
          cursor_row <= area_top;
        end
        REG_AREA_BOTTOM: begin
          area_bottom <= cfg_sext;
          cursor_col  <= area_left;
          cursor_row  <= area_top;
        end
        default: begin
        end
      endcase
    end else if (step && !pos.reject) begin
      if (col_wrap) begin
        cursor_col <= area_left;
        cursor_row <= row_wrap ? area_top : cursor_row + CUR_W'(1);
      end else begin
        cursor_col <= cursor_col + CUR_W'(1);
      end
    end
  end

endmodule

>>> rtl/rgb565_to_mono_frame_writer_unit.sv
// ----------------------------------------------------------------------------
// rgb565_to_mono_frame_writer_unit
// rgb565 pixel stream to packed 1 bit per pixel frame store, with byte reads
// ----------------------------------------------------------------------------
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  in      | in_valid / in_stall   | op, pixel_value, byte_address
//  out     | out_valid / out_stall | read_data, bit_written, area_done, status
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  one request per cycle while in_stall is low: the memory is read when a
//  request is accepted and written back as it moves on from stage 1
//  a back-to-back request to the same byte takes the pending byte by forwarding
//  after reset a clearing pass fills all STORE_BYTES bytes with 0xff, one byte
//  per cycle; in_stall stays high during it, cfg is always taken
//  out_stall holds the result register and, once the stage before it is full,
//  raises in_stall
//
module rgb565_to_mono_frame_writer_unit
  import mfw_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic [15:0]        pixel_value,
  input  logic [BADDR_W-1:0] byte_address,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         read_data,
  output logic               bit_written,
  output logic               area_done,
  output logic               status,
  // register writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [REG_W-1:0]   cfg_data
);

  localparam logic ST_CLEAR = 1'b0;
  localparam logic ST_RUN   = 1'b1;

  logic              state;
  logic [ADDR_W-1:0] clr_cnt;

  pix_pos_t pos;
  logic     accept;
  logic     s1_adv;

  // stage 1: memory read in flight, request details held here
  logic              s1_valid;
  logic              s1_op;
  logic [15:0]       s1_pix;
  logic              s1_in_range;
  logic              s1_reject;
  logic              s1_on_panel;
  logic              s1_last;
  logic [ADDR_W-1:0] s1_addr;
  logic [2:0]        s1_bit_sel;

  logic              fwd_hit;
  logic [7:0]        fwd_data;

  logic              bright;
  logic [7:0]        ram_rdata;
  logic [7:0]        cur_byte;
  logic [7:0]        new_byte;
  logic [7:0]        bit_mask;
  logic              s1_store;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;

  // configuration is always taken
  assign cfg_ready = 1'b1;

  // stage 1 moves on when the result register is free or being emptied
  assign s1_adv   = !out_valid || !out_stall;
  assign in_stall = (state != ST_RUN) || (s1_valid && !s1_adv);
  assign accept   = in_valid && !in_stall;

  mfw_cursor u_cursor (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .step      (accept && (op == OP_PIXEL)),
    .pos       (pos)
  );

  mfw_luma u_luma (
    .pixel  (s1_pix),
    .bright (bright)
  );

  // read-modify-write of the addressed byte
  assign cur_byte = fwd_hit ? fwd_data : ram_rdata;
  assign bit_mask = MSB_MASK >> s1_bit_sel;
  assign new_byte = bright ? (cur_byte | bit_mask) : (cur_byte & ~bit_mask);
  assign s1_store = s1_valid && s1_adv && (s1_op == OP_PIXEL) && !s1_reject && s1_on_panel;

  // clearing pass owns the write port until it finishes
  always_comb begin
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt;
      ram_wdata = BYTE_FILL;
    end else begin
      ram_we    = s1_store;
      ram_waddr = s1_addr;
      ram_wdata = new_byte;
    end
  end

  assign ram_raddr = (op == OP_READ) ? ADDR_W'(byte_address) : pos.addr;

  mfw_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // clearing sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else if (state == ST_CLEAR) begin
      clr_cnt <= clr_cnt + ADDR_W'(1);
      if (clr_cnt == ADDR_W'(STORE_BYTES - 1)) begin
        state <= ST_RUN;
      end
    end
  end

  // stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // stage 1 payload, plus forward of a write that lands on the byte being read
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op       <= op;
      s1_pix      <= pixel_value;
      s1_in_range <= (32'(byte_address) < 32'(STORE_BYTES));
      s1_reject   <= pos.reject;
      s1_on_panel <= pos.on_panel;
      s1_last     <= pos.last;
      s1_addr     <= ram_raddr;
      s1_bit_sel  <= pos.bit_sel;
      fwd_hit     <= s1_store && (s1_addr == ram_raddr);
      fwd_data    <= new_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      if (s1_op == OP_READ) begin
        read_data   <= s1_in_range ? cur_byte : 8'h00;
        bit_written <= 1'b0;
        area_done   <= 1'b0;
        status      <= STATUS_OK;
      end else begin
        read_data   <= 8'h00;
        bit_written <= !s1_reject && s1_on_panel;
        area_done   <= !s1_reject && s1_last;
        status      <= s1_reject ? STATUS_INVERTED : STATUS_OK;
      end
    end
  end

endmodule

>>> rtl/mfw_checker.sv
// ----------------------------------------------------------------------------
// mfw_checker
// port level checks of the mono frame writer, bound to the top level
// ----------------------------------------------------------------------------
module mfw_checker
  import mfw_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [7:0]         read_data,
  input logic               bit_written,
  input logic               area_done,
  input logic               status
);

  // a held result keeps its read data and status
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(status))
    else $error("held result changed");

  // a rejected pixel never stores nor ends the area
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_INVERTED) |-> !bit_written && !area_done)
    else $error("rejected pixel reported as stored");

  // read data only comes with a read, which carries no pixel flags
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (read_data != 8'h00) |-> !bit_written && !area_done && !status)
    else $error("read data on a pixel result");

  // the clearing pass keeps requests out right after reset
  assert property (@(posedge clk)
    rst |=> in_stall && !out_valid)
    else $error("request taken during clearing pass");

  // a stalled request stays on offer until taken
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid)
    else $error("request withdrawn while stalled");

endmodule

bind rgb565_to_mono_frame_writer_unit mfw_checker u_mfw_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .read_data   (read_data),
  .bit_written (bit_written),
  .area_done   (area_done),
  .status      (status)
);
